// ===== rtl/slm_pkg.sv =====
// Shared types and constants for the sorted list merge block.
package slm_pkg;

   localparam int unsigned LIST_DEPTH_DEF = 32;
   localparam int unsigned VALUE_W        = 32;
   localparam int unsigned REQ_TYPE_W     = 2;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_A = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_B = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      value_type             value;
   } req_payload_type;

   typedef struct packed {
      value_type merged_value;
      logic      last;
   } rsp_payload_type;

endpackage

// ===== rtl/slm_list_ram.sv =====
// One list store: single write port, single read port with registered read data.
module slm_list_ram #(
   parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
   parameter int unsigned AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  slm_pkg::value_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output slm_pkg::value_type  rd_data
);

   slm_pkg::value_type mem [LIST_DEPTH];
   slm_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/slm_merge_ctrl.sv =====
// Load bookkeeping, merge sequencer and result register.
module slm_merge_ctrl #(
   parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
   parameter int unsigned AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  slm_pkg::req_payload_type req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output slm_pkg::rsp_payload_type rsp,
   output logic                     we_a,
   output logic                     we_b,
   output logic [AW-1:0]            wr_addr,
   output slm_pkg::value_type       wr_data,
   output logic [AW-1:0]            rd_addr_a,
   output logic [AW-1:0]            rd_addr_b,
   input  slm_pkg::value_type       rd_data_a,
   input  slm_pkg::value_type       rd_data_b,
   output logic                     merge_busy
);

   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic                     state_ff, state_in;
   logic [CW-1:0]            count_a_ff, count_a_in;
   logic [CW-1:0]            count_b_ff, count_b_in;
   logic [CW-1:0]            idx_a_ff, idx_a_in;
   logic [CW-1:0]            idx_b_ff, idx_b_in;
   logic [CW:0]              remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   slm_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic accept, have_a, have_b, take_a, advance, final_pick;

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;

      we_a = accept && (req.req_type == slm_pkg::REQ_LOAD_A)
             && (count_a_ff < CW'(LIST_DEPTH));
      we_b = accept && (req.req_type == slm_pkg::REQ_LOAD_B)
             && (count_b_ff < CW'(LIST_DEPTH));
      wr_addr = we_a ? count_a_ff[AW-1:0] : count_b_ff[AW-1:0];
      wr_data = req.value;

      have_a     = idx_a_ff < count_a_ff;
      have_b     = idx_b_ff < count_b_ff;
      take_a     = have_a && (!have_b || (rd_data_a <= rd_data_b));
      advance    = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_ready);
      final_pick = (remain_ff == (CW+1)'(1));

      if (we_a) begin
         count_a_in = count_a_ff + CW'(1);
      end
      if (we_b) begin
         count_b_in = count_b_ff + CW'(1);
      end

      // Empty start produces nothing and leaves the counts at zero
      if (accept && (req.req_type == slm_pkg::REQ_START)
          && ((count_a_ff != '0) || (count_b_ff != '0))) begin
         state_in  = ST_MERGE;
         remain_in = {1'b0, count_a_ff} + {1'b0, count_b_ff};
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in        = 1'b1;
         rsp_in.merged_value = take_a ? rd_data_a : rd_data_b;
         rsp_in.last         = final_pick;
         remain_in           = remain_ff - (CW+1)'(1);
         if (take_a) begin
            idx_a_in = idx_a_ff + CW'(1);
         end else begin
            idx_b_in = idx_b_ff + CW'(1);
         end
         if (final_pick) begin
            state_in   = ST_IDLE;
            count_a_in = '0;
            count_b_in = '0;
            idx_a_in   = '0;
            idx_b_in   = '0;
         end
      end

      // Address by next index so the read data lines up with the head registers
      rd_addr_a = idx_a_in[AW-1:0];
      rd_addr_b = idx_b_in[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign merge_busy = (state_ff == ST_MERGE);

endmodule

// ===== rtl/sorted_list_merge.sv =====
// Top level of the sorted list merge block.
//
// Load requests (A or B) write one signed value per cycle into that list's
// store; a load into a full list is dropped. A start request streams out
// the two-way merge in ascending order, one result per cycle while the
// consumer keeps rsp_ready high. A start with nA and nB stored entries
// yields nA + nB results, the final one flagged with last. Ties go to list
// A. The rate is set by the two list stores: each has one read port with a
// registered read, and the sequencer holds each list's head in that read
// register, addressing the next entry in the same cycle it consumes the
// current one. Requests are held off (req_ready low) for the length of a
// merge; a start with both lists empty yields no result. After a merge
// both lists are empty again. A result waiting in the output register does
// not block the next load or start. Entries are only read after being
// written, so the stores need no clearing after reset.
module sorted_list_merge #(
   parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  slm_pkg::req_payload_type req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output slm_pkg::rsp_payload_type rsp
);

   localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic               we_a, we_b, merge_busy;
   logic [AW-1:0]      wr_addr, rd_addr_a, rd_addr_b;
   slm_pkg::value_type wr_data, rd_data_a, rd_data_b;

   // Sequencer: counts, indices, compare and result register
   slm_merge_ctrl #(
      .LIST_DEPTH (LIST_DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp),
      .we_a       (we_a),
      .we_b       (we_b),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .merge_busy (merge_busy)
   );

   // List A store
   slm_list_ram #(
      .LIST_DEPTH (LIST_DEPTH),
      .AW         (AW)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   // List B store
   slm_list_ram #(
      .LIST_DEPTH (LIST_DEPTH),
      .AW         (AW)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

`ifndef NO_ASSERTIONS
   // Hold off every request while a merge is streaming
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      merge_busy |-> !req_ready)
      else $error("request accepted during merge");

   // A merge only begins on an accepted start request
   a_merge_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(merge_busy) |-> $past(req_valid && req_ready
                                  && (req.req_type == slm_pkg::REQ_START)))
      else $error("merge began without a start request");

   // The merge ends exactly when the final result has been registered
   a_end_with_last: assert property (@(posedge clock) disable iff (reset)
      $fell(merge_busy) |-> (rsp_valid && rsp.last))
      else $error("merge ended without a final result");
`endif

endmodule

// ===== sim/sorted_list_merge_tb.sv =====
// Self-checking testbench for the sorted list merge block.
module sorted_list_merge_tb;

   localparam int unsigned DEPTH       = slm_pkg::LIST_DEPTH_DEF;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned ITEM_GOAL   = 270;
   localparam int unsigned CALM_FROM   = 230;   // no idling from this request on
   localparam int unsigned DRAIN_WAIT  = 80;    // longer than any merge stream

   // The one request code that the package leaves without a meaning
   localparam logic [slm_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam slm_pkg::value_type VAL_MIN = 32'sh8000_0000;
   localparam slm_pkg::value_type VAL_MAX = 32'sh7fff_ffff;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   slm_pkg::req_payload_type req;
   logic                     rsp_valid;
   logic                     rsp_ready;
   slm_pkg::rsp_payload_type rsp;

   sorted_list_merge #(
      .LIST_DEPTH (DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Predictor state: a private copy of both lists and their fill counts
   slm_pkg::value_type list_a [DEPTH];
   slm_pkg::value_type list_b [DEPTH];
   int unsigned        fill_a;
   int unsigned        fill_b;

   slm_pkg::rsp_payload_type merge_expect [$];   // merged elements still owed by the block

   int unsigned n_accepted;   // requests taken by the block
   int unsigned n_sent;       // requests offered by the sender task
   int unsigned fail_count;
   bit          quiet;        // final stretch: no idling on either side
   bit          calm;         // per-job stretch without idling

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Apply one accepted request to the predictor. A start streams the merge
   // out into the expectation queue, ties going to list A, then empties both
   // lists. Loads into a full list and the unused code leave no trace.
   function automatic void predict_request(input slm_pkg::req_payload_type r);
      int unsigned              ia;
      int unsigned              ib;
      int unsigned              total;
      int unsigned              k;
      slm_pkg::rsp_payload_type item;
      case (r.req_type)
         slm_pkg::REQ_LOAD_A: begin
            if (fill_a < DEPTH) begin
               list_a[fill_a] = r.value;
               fill_a++;
            end
         end
         slm_pkg::REQ_LOAD_B: begin
            if (fill_b < DEPTH) begin
               list_b[fill_b] = r.value;
               fill_b++;
            end
         end
         slm_pkg::REQ_START: begin
            ia = 0;
            ib = 0;
            total = fill_a + fill_b;
            for (k = 0; k < total; k++) begin
               // Signed compare: value_type is a signed vector
               if (ia < fill_a && (ib >= fill_b || list_a[ia] <= list_b[ib])) begin
                  item.merged_value = list_a[ia];
                  ia++;
               end else begin
                  item.merged_value = list_b[ib];
                  ib++;
               end
               item.last = (k + 1 == total);
               merge_expect.push_back(item);
            end
            fill_a = 0;
            fill_b = 0;
         end
         default: begin
            // unused code: drop it
         end
      endcase
   endfunction

   // Scoreboard. Sample both handshakes at the rising edge, before any
   // register in the block moves. Check the result first, then predict from
   // the request, so a start taken while the previous merge is still
   // draining only appends behind it.
   always @(posedge clock) begin : scoreboard
      slm_pkg::rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (merge_expect.size() == 0) begin
               $display("%0t: result with none expected: merged_value %0d last %0b",
                        $time, rsp.merged_value, rsp.last);
               fail_count++;
            end else begin
               want = merge_expect.pop_front();
               if (rsp.merged_value !== want.merged_value) begin
                  $display("%0t: merged_value expected %0d, got %0d",
                           $time, want.merged_value, rsp.merged_value);
                  fail_count++;
               end
               if (rsp.last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last, rsp.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_request(req);
            n_accepted++;
         end
      end
   end

   // Result side back-pressure: stall now and then in bursts, none during the
   // calm stretches.
   always @(negedge clock) begin : rsp_stall
      int unsigned stall_left;
      if (quiet || calm) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one request, called at a falling edge. Idle first now and then;
   // otherwise keep valid high straight through from the previous request.
   // Return at the falling edge after the request was taken.
   task automatic send_request(input logic [slm_pkg::REQ_TYPE_W-1:0] kind,
                               input slm_pkg::value_type v);
      int unsigned target;
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      target = n_accepted + 1;
      req_valid    <= 1'b1;
      req.req_type <= kind;
      req.value    <= v;
      n_sent++;
      while (n_accepted < target) @(negedge clock);
   endtask

   // Starting point of an ascending run: the bottom of the range, anywhere,
   // close to zero, or close to the top.
   function automatic longint ascend_start();
      case ($urandom_range(0, 3))
         0:       return longint'(VAL_MIN);
         1:       return longint'($signed($urandom()));
         2:       return longint'($urandom_range(0, 40)) - 20;
         default: return longint'(VAL_MAX) - longint'($urandom_range(0, 1000));
      endcase
   endfunction

   // Next element of an ascending run; crowded runs repeat values often,
   // and every run saturates at the top of the range.
   function automatic longint ascend_next(input longint cur, input bit crowded);
      longint nxt;
      if (crowded)
         nxt = cur + $urandom_range(0, 2);
      else if ($urandom_range(0, 7) == 0)
         nxt = cur + longint'($urandom_range(0, 32'h7fff_ffff));
      else
         nxt = cur + $urandom_range(0, 1 << 24);
      if (nxt > longint'(VAL_MAX))
         nxt = longint'(VAL_MAX);
      return nxt;
   endfunction

   // One well-formed job: two ascending lists, loads of A and B interleaved
   // at random, then a start.
   task automatic run_merge_job(input int unsigned len_a, input int unsigned len_b,
                                input bit crowded);
      int unsigned done_a;
      int unsigned done_b;
      longint      cur_a;
      longint      cur_b;
      done_a = 0;
      done_b = 0;
      cur_a  = ascend_start();
      cur_b  = crowded ? cur_a : ascend_start();
      while (done_a < len_a || done_b < len_b) begin
         if (done_b == len_b || (done_a < len_a && $urandom_range(0, 1) == 1)) begin
            send_request(slm_pkg::REQ_LOAD_A, slm_pkg::value_type'(cur_a));
            cur_a = ascend_next(cur_a, crowded);
            done_a++;
         end else begin
            send_request(slm_pkg::REQ_LOAD_B, slm_pkg::value_type'(cur_b));
            cur_b = ascend_next(cur_b, crowded);
            done_b++;
         end
      end
      send_request(slm_pkg::REQ_START, slm_pkg::value_type'($urandom()));
   endtask

   // Range extremes, all-ones and zero, with ties at both ends of the range
   task automatic test_extremes();
      send_request(slm_pkg::REQ_LOAD_A, VAL_MIN);
      send_request(slm_pkg::REQ_LOAD_A, -32'sd1);
      send_request(slm_pkg::REQ_LOAD_A, VAL_MAX);
      send_request(slm_pkg::REQ_LOAD_B, VAL_MIN);
      send_request(slm_pkg::REQ_LOAD_B, 32'sd0);
      send_request(slm_pkg::REQ_LOAD_B, VAL_MAX);
      send_request(slm_pkg::REQ_START, VAL_MAX);
   endtask

   // Start with nothing loaded, twice in a row: no result either time
   task automatic test_empty_start();
      send_request(slm_pkg::REQ_START, 32'sd0);
      send_request(slm_pkg::REQ_START, -32'sd1);
   endtask

   // Unused code between loads must leave both lists untouched
   task automatic test_unused_code();
      send_request(slm_pkg::REQ_LOAD_A, 32'sd5);
      send_request(REQ_UNUSED, 32'sd1);
      send_request(slm_pkg::REQ_LOAD_B, 32'sd3);
      send_request(REQ_UNUSED, VAL_MIN);
      send_request(slm_pkg::REQ_START, 32'sd0);
   endtask

   // Only one list populated: straight copy-out of that list
   task automatic test_one_sided();
      send_request(slm_pkg::REQ_LOAD_A, -32'sd7);
      send_request(slm_pkg::REQ_LOAD_A, 32'sd12);
      send_request(slm_pkg::REQ_START, 32'sd0);
      send_request(slm_pkg::REQ_LOAD_B, 32'sd42);
      send_request(slm_pkg::REQ_START, 32'sd0);
   endtask

   // Lists out of order: same head-compare procedure, unsorted output
   task automatic test_unsorted();
      send_request(slm_pkg::REQ_LOAD_A, 32'sd9);
      send_request(slm_pkg::REQ_LOAD_A, -32'sd4);
      send_request(slm_pkg::REQ_LOAD_B, 32'sd3);
      send_request(slm_pkg::REQ_LOAD_A, 32'sd7);
      send_request(slm_pkg::REQ_LOAD_B, 32'sd3);
      send_request(slm_pkg::REQ_START, 32'sd0);
   endtask

   // Overfill both lists: surplus loads dropped, longest possible merge
   task automatic test_capacity();
      run_merge_job(DEPTH + 1, DEPTH + 2, 1'b0);
      run_merge_job(DEPTH + 3, DEPTH, 1'b1);
   endtask

   // Mostly well-formed jobs of mostly short lists, some of them long; the
   // rest is noise with every code and any value, in any order.
   task automatic test_random();
      int unsigned noise_len;
      int unsigned len_a;
      int unsigned len_b;
      while (n_sent < ITEM_GOAL) begin
         quiet = (n_sent >= CALM_FROM);
         calm  = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) == 0) begin
            noise_len = $urandom_range(1, 8);
            repeat (noise_len)
               send_request(slm_pkg::REQ_TYPE_W'($urandom_range(0, 3)),
                            slm_pkg::value_type'($urandom()));
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               len_a = $urandom_range(0, DEPTH + 2);
               len_b = $urandom_range(0, DEPTH + 2);
            end else begin
               len_a = $urandom_range(0, 6);
               len_b = $urandom_range(0, 6);
            end
            run_merge_job(len_a, len_b, $urandom_range(0, 2) == 0);
         end
      end
      calm = 1'b0;
   endtask

   // Watchdog: end the run if the block hangs or owes results for ever
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL sorted_list_merge");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req        = '0;
      rsp_ready  = 1'b0;
      fill_a     = 0;
      fill_b     = 0;
      n_accepted = 0;
      n_sent     = 0;
      fail_count = 0;
      quiet      = 1'b0;
      calm       = 1'b0;

      // Hold reset, then release it on a falling edge
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes();
      test_empty_start();
      test_unused_code();
      test_one_sided();
      test_unsorted();
      test_capacity();
      test_random();

      // Drop valid, drain the merge still in flight, then allow a margin in
      // which any stray result would be caught by the scoreboard.
      req_valid <= 1'b0;
      while (merge_expect.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (fail_count == 0)
         $display("PASS sorted_list_merge");
      else
         $display("FAIL sorted_list_merge");
      $finish;
   end

endmodule
